### sv/power_mode_window_controller_macros.svh
// ----------------------------------------------------------------------------
// Power mode window controller assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef POWER_MODE_WINDOW_CONTROLLER_MACROS_SVH
`define POWER_MODE_WINDOW_CONTROLLER_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define PMWC_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define PMWC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pmwc_pkg.sv
// ----------------------------------------------------------------------------
// pmwc_pkg
// Types, codes and helpers shared by the power mode window controller.
// ----------------------------------------------------------------------------
package pmwc_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned NOW_W     = 48;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned WAKE_W    = 3;
  localparam int unsigned REM_W     = 27;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned NUM_CHOICES     = 4;
  localparam int unsigned NUM_CHOICE_REGS = 4;
  localparam int unsigned USED_CHOICES    =
    (NUM_CHOICES < NUM_CHOICE_REGS) ? NUM_CHOICES : NUM_CHOICE_REGS;

  localparam int unsigned MS_PER_MIN = 60 * 1000;

  typedef enum logic [OP_W-1:0] {
    OP_BOOT       = 2'd0,
    OP_REQUEST    = 2'd1,
    OP_SET_LENGTH = 2'd2,
    OP_TICK       = 2'd3
  } op_t;

  localparam logic [MODE_W-1:0] MODE_AUTO_SAVER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INTERACTIVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALWAYS_ON  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNKNOWN    = 2'd3;

  localparam logic [WAKE_W-1:0] WAKE_POWER_ON = 3'd0;
  localparam logic [WAKE_W-1:0] WAKE_BUTTON   = 3'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHOICE_A       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHOICE_B       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHOICE_C       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHOICE_D       = 3'd4;

  localparam logic [LEN_W-1:0] DEFAULT_WINDOW_RESET = 11'd15;
  localparam logic [LEN_W-1:0] STORED_LENGTH_RESET  = 11'd15;
  localparam logic [NUM_CHOICE_REGS-1:0][LEN_W-1:0] CHOICE_RESET =
    {11'd60, 11'd30, 11'd15, 11'd5};

  typedef struct packed {
    logic [LEN_W-1:0]                      default_min;
    logic [NUM_CHOICE_REGS-1:0][LEN_W-1:0] choice;
  } cfg_t;

  typedef struct packed {
    op_t               op;
    logic [NOW_W-1:0]  now_ms;
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  minutes;
    logic [WAKE_W-1:0] wake_reason;
  } item_t;

  typedef struct packed {
    logic              ok;
    logic              window_expired;
    logic [MODE_W-1:0] in_force_mode;
    logic [MODE_W-1:0] wanted_mode;
    logic              ack_pending;
    logic [REM_W-1:0]  left_ms;
    logic [MODE_W-1:0] persistable_mode;
  } result_t;

  // A length is permitted when it matches one of the used choices.
  function automatic logic length_valid(input cfg_t cfg, input logic [LEN_W-1:0] m);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < USED_CHOICES; i++) begin
      if (cfg.choice[i] == m) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

### sv/pmwc_cfg_regs.sv
// ----------------------------------------------------------------------------
// pmwc_cfg_regs
// Configuration registers: default window length and permitted lengths.
// ----------------------------------------------------------------------------
module pmwc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [pmwc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [pmwc_pkg::LEN_W-1:0]     wr_data,
  output pmwc_pkg::cfg_t                cfg
);
  import pmwc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.default_min <= DEFAULT_WINDOW_RESET;
      cfg_r.choice      <= CHOICE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_DEFAULT_WINDOW: cfg_r.default_min <= wr_data;
        CFG_CHOICE_A:       cfg_r.choice[0]   <= wr_data;
        CFG_CHOICE_B:       cfg_r.choice[1]   <= wr_data;
        CFG_CHOICE_C:       cfg_r.choice[2]   <= wr_data;
        CFG_CHOICE_D:       cfg_r.choice[3]   <= wr_data;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/pmwc_remaining.sv
// ----------------------------------------------------------------------------
// pmwc_remaining
// Time left in the interactive window at a given timestamp.
// ----------------------------------------------------------------------------
module pmwc_remaining (
  input  logic                       window_open,
  input  logic [pmwc_pkg::NOW_W-1:0] start_ms,
  input  logic [pmwc_pkg::REM_W-1:0] dur_ms,
  input  logic [pmwc_pkg::NOW_W-1:0] now_ms,
  output logic [pmwc_pkg::REM_W-1:0] left_ms
);
  import pmwc_pkg::*;

  logic [NOW_W-1:0] elapsed;

  assign elapsed = now_ms - start_ms;

  always_comb begin
    if (!window_open || (dur_ms == '0)) begin
      left_ms = '0;
    end else if (now_ms < start_ms) begin
      // backwards clock: no time has passed
      left_ms = dur_ms;
    end else if (elapsed >= NOW_W'(dur_ms)) begin
      left_ms = '0;
    end else begin
      left_ms = dur_ms - elapsed[REM_W-1:0];
    end
  end

endmodule

### sv/pmwc_core.sv
// ----------------------------------------------------------------------------
// pmwc_core
// Mode and window state with the per-item update and result logic.
// ----------------------------------------------------------------------------
module pmwc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_en,
  input  pmwc_pkg::item_t   item,
  input  pmwc_pkg::cfg_t    cfg,
  output pmwc_pkg::result_t result
);
  import pmwc_pkg::*;

  logic [MODE_W-1:0] base_mode_r,    base_mode_nxt;
  logic [MODE_W-1:0] wanted_mode_r,  wanted_mode_nxt;
  logic              window_open_r,  window_open_nxt;
  logic [NOW_W-1:0]  window_start_r, window_start_nxt;
  logic [REM_W-1:0]  window_dur_r,   window_dur_nxt;
  logic              seen_open_r,    seen_open_nxt;
  logic [LEN_W-1:0]  stored_len_r,   stored_len_nxt;

  logic              mins_valid, default_valid, stored_valid;
  logic [LEN_W-1:0]  boot_len, req_len, open_len;
  logic              req_valid, user_wake;
  logic [REM_W-1:0]  open_dur;
  logic [REM_W-1:0]  rem_pre, rem_post;
  logic              ok, expired;
  logic [MODE_W-1:0] eff_mode;

  pmwc_remaining u_remaining (
    .window_open (window_open_r),
    .start_ms    (window_start_r),
    .dur_ms      (window_dur_r),
    .now_ms      (item.now_ms),
    .left_ms     (rem_pre)
  );

  assign mins_valid    = length_valid(cfg, item.minutes);
  assign default_valid = length_valid(cfg, cfg.default_min);
  assign stored_valid  = length_valid(cfg, stored_len_r);

  assign boot_len  = mins_valid ? item.minutes : cfg.default_min;
  assign req_len   = (item.minutes == '0) ? stored_len_r : item.minutes;
  assign req_valid = (item.minutes == '0) ? stored_valid : mins_valid;
  assign open_len  = (item.op == OP_BOOT) ? boot_len : req_len;
  assign open_dur  = REM_W'(open_len) * REM_W'(MS_PER_MIN);
  assign user_wake = (item.wake_reason == WAKE_POWER_ON) ||
                     (item.wake_reason == WAKE_BUTTON);

  always_comb begin
    base_mode_nxt    = base_mode_r;
    wanted_mode_nxt  = wanted_mode_r;
    window_open_nxt  = window_open_r;
    window_start_nxt = window_start_r;
    window_dur_nxt   = window_dur_r;
    seen_open_nxt    = seen_open_r;
    stored_len_nxt   = stored_len_r;
    ok               = 1'b1;
    expired          = 1'b0;
    rem_post         = rem_pre;

    case (item.op)
      OP_BOOT: begin
        base_mode_nxt    = (item.mode == MODE_INTERACTIVE) ? MODE_AUTO_SAVER : item.mode;
        wanted_mode_nxt  = base_mode_nxt;
        stored_len_nxt   = boot_len;
        window_open_nxt  = 1'b0;
        window_start_nxt = '0;
        window_dur_nxt   = '0;
        seen_open_nxt    = 1'b0;
        rem_post         = '0;
        if (user_wake && (base_mode_nxt != MODE_ALWAYS_ON)) begin
          wanted_mode_nxt = MODE_INTERACTIVE;
          seen_open_nxt   = 1'b1;
          // the window opens only when the given length or the fallback length is permitted
          if (mins_valid || default_valid) begin
            window_open_nxt  = 1'b1;
            window_start_nxt = item.now_ms;
            window_dur_nxt   = open_dur;
            rem_post         = open_dur;
          end
        end
      end
      OP_REQUEST: begin
        if (item.mode == MODE_INTERACTIVE) begin
          if (!req_valid) begin
            ok = 1'b0;
          end else begin
            stored_len_nxt   = req_len;
            base_mode_nxt    = MODE_AUTO_SAVER;
            window_open_nxt  = 1'b1;
            window_start_nxt = item.now_ms;
            window_dur_nxt   = open_dur;
            seen_open_nxt    = 1'b1;
            wanted_mode_nxt  = MODE_INTERACTIVE;
            rem_post         = open_dur;
          end
        end else if (item.mode == MODE_UNKNOWN) begin
          ok = 1'b0;
        end else begin
          window_open_nxt  = 1'b0;
          window_start_nxt = '0;
          window_dur_nxt   = '0;
          seen_open_nxt    = 1'b0;
          base_mode_nxt    = item.mode;
          wanted_mode_nxt  = item.mode;
          rem_post         = '0;
        end
      end
      OP_SET_LENGTH: begin
        if (mins_valid) begin
          stored_len_nxt = item.minutes;
        end else begin
          ok = 1'b0;
        end
      end
      OP_TICK: begin
        if (seen_open_r && (rem_pre == '0)) begin
          seen_open_nxt    = 1'b0;
          window_open_nxt  = 1'b0;
          window_start_nxt = '0;
          window_dur_nxt   = '0;
          wanted_mode_nxt  = base_mode_r;
          expired          = 1'b1;
        end else begin
          seen_open_nxt = (rem_pre != '0);
        end
      end
      default: begin
        ok = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (base_mode_nxt == MODE_ALWAYS_ON) begin
      eff_mode = MODE_ALWAYS_ON;
    end else if (rem_post != '0) begin
      eff_mode = MODE_INTERACTIVE;
    end else begin
      eff_mode = MODE_AUTO_SAVER;
    end
  end

  assign result.ok               = ok;
  assign result.window_expired   = expired;
  assign result.in_force_mode    = eff_mode;
  assign result.wanted_mode      = wanted_mode_nxt;
  assign result.ack_pending      = (eff_mode != wanted_mode_nxt);
  assign result.left_ms          = rem_post;
  assign result.persistable_mode =
    (base_mode_nxt == MODE_INTERACTIVE) ? MODE_AUTO_SAVER : base_mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_mode_r    <= MODE_AUTO_SAVER;
      wanted_mode_r  <= MODE_AUTO_SAVER;
      window_open_r  <= 1'b0;
      window_start_r <= '0;
      window_dur_r   <= '0;
      seen_open_r    <= 1'b0;
      stored_len_r   <= STORED_LENGTH_RESET;
    end else if (item_en) begin
      base_mode_r    <= base_mode_nxt;
      wanted_mode_r  <= wanted_mode_nxt;
      window_open_r  <= window_open_nxt;
      window_start_r <= window_start_nxt;
      window_dur_r   <= window_dur_nxt;
      seen_open_r    <= seen_open_nxt;
      stored_len_r   <= stored_len_nxt;
    end
  end

endmodule

### sv/power_mode_window_controller.sv
// ----------------------------------------------------------------------------
// power_mode_window_controller
// Power-mode controller with a timed interactive window.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle, sustained, while out_ready keeps the result
// register draining. An accepted item waits in the input register, and one
// pass through the state update loads its result into the result register,
// which drives the out_ ports. That update pass holds a tick's window compare
// (48-bit elapsed time against the stored duration) and the mode and window
// state it rewrites, between the input register and the result register.
// The result register frees the input side: a new item is taken while a
// finished result still waits, as long as the result is taken in the same
// cycle or the input register is empty.
// Configuration writes are always taken (cfg_ready is tied high) and belong
// to idle periods; writes to indexes past the last choice are dropped. No
// clearing pass is needed after reset.
module power_mode_window_controller (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pmwc_pkg::OP_W-1:0]      in_operation,
  input  logic [pmwc_pkg::NOW_W-1:0]     in_now_ms,
  input  logic [pmwc_pkg::MODE_W-1:0]    in_mode,
  input  logic [pmwc_pkg::LEN_W-1:0]     in_minutes,
  input  logic [pmwc_pkg::WAKE_W-1:0]    in_wake_reason,

  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_ok,
  output logic                           out_window_expired,
  output logic [pmwc_pkg::MODE_W-1:0]    out_effective_mode,
  output logic [pmwc_pkg::MODE_W-1:0]    out_desired_mode,
  output logic                           out_ack_pending,
  output logic [pmwc_pkg::REM_W-1:0]     out_remaining_ms,
  output logic [pmwc_pkg::MODE_W-1:0]    out_persistable_mode,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pmwc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pmwc_pkg::LEN_W-1:0]     cfg_data
);
  import pmwc_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  result_t result, result_r;
  logic    in_valid_r, in_valid_nxt;
  logic    out_valid_r;
  logic    advance, stage_fire, in_fire;

  // Config registers accept a write every cycle.
  assign cfg_ready = 1'b1;

  pmwc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the result register when it is empty or being drained.
  assign advance    = !out_valid_r || out_ready;
  assign stage_fire = in_valid_r && advance;
  assign in_ready   = !in_valid_r || advance;
  assign in_fire    = in_valid && in_ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) begin
      in_valid_nxt = 1'b1;
    end else if (stage_fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  // Hold the accepted item until its result moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.op          <= op_t'(in_operation);
      item_r.now_ms      <= in_now_ms;
      item_r.mode        <= in_mode;
      item_r.minutes     <= in_minutes;
      item_r.wake_reason <= in_wake_reason;
    end
  end

  // State commits exactly when the item's result is captured.
  pmwc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (stage_fire),
    .item    (item_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire) begin
      result_r <= result;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_ok               = result_r.ok;
  assign out_window_expired   = result_r.window_expired;
  assign out_effective_mode   = result_r.in_force_mode;
  assign out_desired_mode     = result_r.wanted_mode;
  assign out_ack_pending      = result_r.ack_pending;
  assign out_remaining_ms     = result_r.left_ms;
  assign out_persistable_mode = result_r.persistable_mode;

endmodule

### sv/pmwc_checker.sv
// ----------------------------------------------------------------------------
// pmwc_checker
// Port-level checks on the result channel of the controller.
// ----------------------------------------------------------------------------
`include "power_mode_window_controller_macros.svh"

module pmwc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_ok,
  input logic                        out_window_expired,
  input logic [pmwc_pkg::MODE_W-1:0] out_effective_mode,
  input logic [pmwc_pkg::MODE_W-1:0] out_desired_mode,
  input logic                        out_ack_pending,
  input logic [pmwc_pkg::REM_W-1:0]  out_remaining_ms
);
  import pmwc_pkg::*;

  `PMWC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_remaining_ms) && $stable(out_desired_mode), "stalled result changed")
  `PMWC_ASSERT_NOW(a_ack_match, clk, rst_n, out_valid, out_ack_pending == (out_effective_mode != out_desired_mode), "ack_pending inconsistent")
  `PMWC_ASSERT_NOW(a_expiry_closed, clk, rst_n, out_valid && out_window_expired, out_ok && (out_remaining_ms == '0), "expiry with time left")
  `PMWC_ASSERT_NOW(a_open_not_saver, clk, rst_n, out_valid && (out_remaining_ms != '0), out_effective_mode != MODE_AUTO_SAVER, "open window in auto saver")

endmodule

bind power_mode_window_controller pmwc_checker u_pmwc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_ok             (out_ok),
  .out_window_expired (out_window_expired),
  .out_effective_mode (out_effective_mode),
  .out_desired_mode   (out_desired_mode),
  .out_ack_pending    (out_ack_pending),
  .out_remaining_ms   (out_remaining_ms)
);
